// File: sv/fni_pkg.sv
// ----------------------------------------------------------------------------
// fni_pkg
// Shared constants and types for the first-negative-in-window block.
// ----------------------------------------------------------------------------
package fni_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 32;
    localparam int POS_BITS    = 32;
    localparam int ADDR_BITS   = $clog2(MAX_WINDOW);
    localparam int COUNT_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int WS_BITS     = 7;

    localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(MAX_WINDOW);
    localparam logic [WS_BITS-1:0]    WS_MAX     = WS_BITS'(MAX_WINDOW);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] val;
        logic [POS_BITS-1:0]    pos;
    } entry_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
        entry_t               data;
    } wr_req_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic                  filled;
    } status_t;

endpackage

// File: sv/fni_store.sv
// ----------------------------------------------------------------------------
// fni_store
// Queue entry memory: one write port, one registered read port with
// write-through bypass.
// ----------------------------------------------------------------------------
module fni_store
(
    input  logic                         clk,
    input  fni_pkg::wr_req_t             wr,
    input  logic                         rd_en,
    input  logic [fni_pkg::ADDR_BITS-1:0] rd_addr,
    output fni_pkg::entry_t              rd_data
);

    fni_pkg::entry_t mem [fni_pkg::MAX_WINDOW];
    fni_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            if (wr.en && (wr.addr == rd_addr))
            begin
                rd_data_reg <= wr.data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/fni_core.sv
// ----------------------------------------------------------------------------
// fni_core
// Queue control: age-out of the front entry, append of negative samples,
// front entry cache and result selection.
// ----------------------------------------------------------------------------
module fni_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic [fni_pkg::SAMPLE_BITS-1:0] smp,
    input  logic                           start,
    input  logic [fni_pkg::WS_BITS-1:0]    ws,
    output logic                           res,
    output logic [fni_pkg::SAMPLE_BITS-1:0] res_val,
    output fni_pkg::status_t               status
);

    logic [fni_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic [fni_pkg::ADDR_BITS-1:0]  head_reg, head_next;
    logic [fni_pkg::ADDR_BITS-1:0]  tail_reg, tail_next;
    logic [fni_pkg::POS_BITS-1:0]   pos_reg, pos_next;
    logic                           filled_reg, filled_next;
    fni_pkg::entry_t                front_reg, front_next;

    logic [fni_pkg::WS_BITS-1:0]    k;
    logic [fni_pkg::COUNT_BITS-1:0] c0, c1;
    logic [fni_pkg::ADDR_BITS-1:0]  h0, t0;
    logic [fni_pkg::POS_BITS-1:0]   p, age;
    logic                           f0, deq, enq;
    logic [fni_pkg::POS_BITS:0]     p_inc;
    fni_pkg::entry_t                sec;
    fni_pkg::wr_req_t               wr;

    fni_store u_store
    (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (adv),
        .rd_addr (head_next + fni_pkg::ADDR_BITS'(1)),
        .rd_data (sec)
    );

    always_comb
    begin
        if (ws == '0)
        begin
            k = fni_pkg::WS_BITS'(1);
        end
        else if (ws > fni_pkg::WS_MAX)
        begin
            k = fni_pkg::WS_MAX;
        end
        else
        begin
            k = ws;
        end

        c0 = start ? '0 : count_reg;
        h0 = start ? '0 : head_reg;
        t0 = start ? '0 : tail_reg;
        p  = start ? '0 : pos_reg;
        f0 = start ? 1'b0 : filled_reg;

        age = p - front_reg.pos;
        deq = (c0 != '0) && (age >= fni_pkg::POS_BITS'(k));
        c1  = c0 - fni_pkg::COUNT_BITS'(deq);
        head_next = h0 + fni_pkg::ADDR_BITS'(deq);

        enq = smp[fni_pkg::SAMPLE_BITS-1] && (c1 != fni_pkg::COUNT_FULL);
        count_next = c1 + fni_pkg::COUNT_BITS'(enq);
        tail_next  = t0 + fni_pkg::ADDR_BITS'(enq);

        wr.en       = adv && enq;
        wr.addr     = t0;
        wr.data.val = smp;
        wr.data.pos = p;

        if (enq && (c1 == '0))
        begin
            front_next = wr.data;
        end
        else if (deq)
        begin
            front_next = sec;
        end
        else
        begin
            front_next = front_reg;
        end

        p_inc       = {1'b0, p} + (fni_pkg::POS_BITS + 1)'(1);
        filled_next = f0 || (p_inc >= (fni_pkg::POS_BITS + 1)'(k));
        pos_next    = p_inc[fni_pkg::POS_BITS-1:0];

        res     = filled_next;
        res_val = (count_next != '0) ? front_next.val : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            pos_reg    <= '0;
            filled_reg <= 1'b0;
        end
        else if (adv)
        begin
            count_reg  <= count_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            pos_reg    <= pos_next;
            filled_reg <= filled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            front_reg <= front_next;
        end
    end

    assign status.count  = count_reg;
    assign status.filled = filled_reg;

endmodule

// File: sv/first_negative_in_window.sv
// ----------------------------------------------------------------------------
// first_negative_in_window
// Oldest negative sample in a sliding window over a signed sample stream.
// ----------------------------------------------------------------------------
// Result: the input register feeds the queue update, which loads the result
// register. Throughput: one sample per cycle unless the output stalls,
// set by the single queue update per sample.
// Reset: queue empty, sequence restarted, window_size = 1; entry memory is
// not cleared and needs no clearing pass.
module first_negative_in_window
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 window_size_we,
    input  logic [fni_pkg::WS_BITS-1:0]          window_size,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [fni_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                 start_req,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [fni_pkg::SAMPLE_BITS-1:0] first_negative
);

    logic [fni_pkg::WS_BITS-1:0]     ws_reg;
    logic                            in_valid_reg;
    logic [fni_pkg::SAMPLE_BITS-1:0] sample_reg;
    logic                            start_reg;
    logic                            out_valid_reg;
    logic [fni_pkg::SAMPLE_BITS-1:0] result_reg;

    logic                            adv;
    logic                            res;
    logic [fni_pkg::SAMPLE_BITS-1:0] res_val;
    fni_pkg::status_t                status;

    fni_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .smp     (sample_reg),
        .start   (start_reg),
        .ws      (ws_reg),
        .res     (res),
        .res_val (res_val),
        .status  (status)
    );

    assign adv      = in_valid_reg && (!res || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg        <= fni_pkg::WS_BITS'(1);
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (window_size_we)
            begin
                ws_reg <= window_size;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (adv && res)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg <= sample;
            start_reg  <= start_req;
        end
        if (adv && res)
        begin
            result_reg <= res_val;
        end
    end

    assign out_valid      = out_valid_reg;
    assign first_negative = result_reg;

    // queue never holds more than the entry memory
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.count <= fni_pkg::COUNT_FULL)
        else $error("queue count above capacity");

    // a result is either zero or a negative sample
    a_result_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (first_negative[fni_pkg::SAMPLE_BITS-1] || (first_negative == '0)))
        else $error("positive result");

    // a processed sample with a result shows up at the output next cycle
    a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res) |=> (out_valid && (first_negative == $past(res_val))))
        else $error("result lost");

endmodule
